### sv/schalloc_pkg.sv
// Shared constants for the size-class heap allocator: request codes,
// result codes and default sizing. No dependencies.
`default_nettype none
package schalloc_pkg;

    localparam int DEF_HEAP_WORDS  = 65536;
    localparam int DEF_NUM_CLASSES = 17;
    localparam int DEF_HEAP_START  = 16;

    localparam logic [3:0] OP_ALLOC    = 4'd0;
    localparam logic [3:0] OP_FREE     = 4'd1;
    localparam logic [3:0] OP_SPAN     = 4'd2;
    localparam logic [3:0] OP_ACHECK   = 4'd3;
    localparam logic [3:0] OP_SEAL     = 4'd4;
    localparam logic [3:0] OP_UNSEAL   = 4'd5;
    localparam logic [3:0] OP_MARK_RAW = 4'd6;
    localparam logic [3:0] OP_MARK_OWN = 4'd7;
    localparam logic [3:0] OP_QUERY    = 4'd8;

    localparam logic [2:0] E_OK       = 3'd0;
    localparam logic [2:0] E_CLASS    = 3'd1;
    localparam logic [2:0] E_LIST     = 3'd2;
    localparam logic [2:0] E_BUDGET   = 3'd3;
    localparam logic [2:0] E_SPAN     = 3'd4;
    localparam logic [2:0] E_MISMATCH = 3'd5;
    localparam logic [2:0] E_HEAD     = 3'd6;
    localparam logic [2:0] E_SEALED   = 3'd7;

endpackage
`default_nettype wire

### sv/schalloc_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
// Depends on schalloc_pkg for the default depth; contents are undefined until written.
`default_nettype none
module schalloc_ram
    import schalloc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEF_HEAP_WORDS
)(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/size_class_heap_allocator_core.sv
// Size-class heap allocator core: sequencer, metadata and link memories.
// Uses schalloc_pkg and schalloc_ram.
//
// One request is taken at a time; in_stall stays high until its result beat
// has been taken. Every request walks one metadata memory port, one access
// per cycle, under a small sequencer. Alloc writes the metadata of every word
// of the block (2^class words), taking it from the class free list or from
// the bump pointer; free checks the block head and rewrites every word of
// the block; mark reads, waits on and writes back each marked word. Word
// metadata needs no clearing pass: only words below the bump pointer are ever
// read, and all of them were written when the bump pointer passed them.
`default_nettype none
module size_class_heap_allocator_core
    import schalloc_pkg::*;
#(
    parameter int HEAP_WORDS  = DEF_HEAP_WORDS,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES,
    parameter int HEAP_START  = DEF_HEAP_START
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  op,
    input  wire logic [4:0]  size_class,
    input  wire logic [15:0] address,
    input  wire logic [16:0] word_count,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      block_address,
    output logic [2:0]       error_code,
    output logic             owned_flag,
    output logic             sealed_flag,
    output logic [16:0]      live_word_total,
    output logic [16:0]      live_block_total
);
    localparam int AW  = $clog2(HEAP_WORDS);      // memory index
    localparam int PW  = AW + 1;                  // bump pointer
    localparam int XM  = (PW > NUM_CLASSES) ? PW : NUM_CLASSES;
    localparam int XW  = ((XM > 17) ? XM : 17) + 1; // compare/adder width
    localparam int MW  = AW + 8;                  // owner, class+1, 3 flags
    localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int B_SEALED = AW + 5;
    localparam int B_FREE   = AW + 6;
    localparam int B_OWNED  = AW + 7;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_LIST   = 4'd2;
    localparam logic [3:0] S_SPAN   = 4'd3;
    localparam logic [3:0] S_OWNER  = 4'd4;
    localparam logic [3:0] S_FILL   = 4'd5;
    localparam logic [3:0] S_MRD    = 4'd6;
    localparam logic [3:0] S_MWAIT  = 4'd7;
    localparam logic [3:0] S_MWR    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam logic [XW-1:0] HW_X = XW'(HEAP_WORDS);
    localparam logic [XW-1:0] HS_X = XW'(HEAP_START);
    localparam logic [XW-1:0] NC_X = XW'(NUM_CLASSES);

    logic [3:0]    state_reg, state_next;
    logic [3:0]    op_reg, op_next;
    logic [4:0]    cls_reg, cls_next;
    logic [15:0]   at_reg, at_next;
    logic [16:0]   cnt_reg, cnt_next;
    logic [16:0]   cap_reg;
    logic [PW-1:0] bump_reg, bump_next;
    logic [16:0]   lw_reg, lw_next;
    logic [16:0]   lb_reg, lb_next;
    logic [AW-1:0] heads_reg [NUM_CLASSES];
    logic [AW-1:0] head_wdata;
    logic          head_we;
    logic [MW-1:0] m_reg, m_next;
    logic [AW-1:0] base_reg, base_next;
    logic [XW-1:0] idx_reg, idx_next;
    logic          ffree_reg, ffree_next;
    logic [15:0]   addr_reg, addr_next;
    logic [2:0]    err_reg, err_next;
    logic          own_reg, own_next;
    logic          seal_reg, seal_next;

    logic          meta_we;
    logic [AW-1:0] meta_waddr, meta_raddr;
    logic [MW-1:0] meta_wdata, meta_rdata;
    logic          link_we;
    logic [AW-1:0] link_wdata, link_rdata;

    // shared datapath terms
    logic [XW-1:0] at_x, bump_x, cap_x, size_c, head_x, walk_x;
    logic [CW-1:0] cls_ix;
    logic [AW-1:0] head_cur;
    logic          cls_ok;
    logic [MW-1:0] meta_new;
    logic [XW-1:0] own_x, off_x, size_m, cnt_x;
    logic [4:0]    cp1;
    logic          span_ok, match_ok;

    schalloc_ram #(.WIDTH(MW), .DEPTH(HEAP_WORDS)) u_meta (
        .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
        .raddr(meta_raddr), .rdata(meta_rdata)
    );

    schalloc_ram #(.WIDTH(AW), .DEPTH(HEAP_WORDS)) u_link (
        .clk(clk), .we(link_we), .waddr(at_x[AW-1:0]), .wdata(link_wdata),
        .raddr(head_cur), .rdata(link_rdata)
    );

    always_comb
    begin
        at_x     = XW'(at_reg);
        bump_x   = XW'(bump_reg);
        cap_x    = (XW'(cap_reg) < HW_X) ? XW'(cap_reg) : HW_X;
        cls_ok   = XW'(cls_reg) < NC_X;
        cls_ix   = cls_reg[CW-1:0];
        head_cur = heads_reg[cls_ix];
        head_x   = XW'(head_cur);
        size_c   = cls_ok ? (XW'(1) << cls_reg) : '0;
        walk_x   = XW'(base_reg) + idx_reg;
        meta_new = {3'b000, 5'(cls_reg + 5'd1), base_reg};
        // span rule on the word just read
        own_x    = XW'(meta_rdata[AW-1:0]);
        cp1      = meta_rdata[AW+4:AW];
        size_m   = XW'(1) << (cp1 - 5'd1);
        off_x    = at_x - own_x;
        cnt_x    = (op_reg == OP_SPAN || op_reg == OP_MARK_RAW || op_reg == OP_MARK_OWN)
                   ? XW'(cnt_reg) : XW'(1);
        span_ok  = (meta_rdata != '0) && !meta_rdata[B_FREE] && (own_x >= HS_X)
                   && (own_x <= at_x) && (cp1 != 5'd0) && (XW'(cp1 - 5'd1) < NC_X)
                   && (off_x < size_m) && (cnt_x <= size_m - off_x);
        match_ok = cls_ok && ({3'b000, meta_rdata[AW+4:0]}
                   == {3'b000, 5'(cls_reg + 5'd1), at_x[AW-1:0]});
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cls_next   = cls_reg;
        at_next    = at_reg;
        cnt_next   = cnt_reg;
        bump_next  = bump_reg;
        lw_next    = lw_reg;
        lb_next    = lb_reg;
        m_next     = m_reg;
        base_next  = base_reg;
        idx_next   = idx_reg;
        ffree_next = ffree_reg;
        addr_next  = addr_reg;
        err_next   = err_reg;
        own_next   = own_reg;
        seal_next  = seal_reg;
        head_we    = 1'b0;
        head_wdata = base_reg;
        meta_we    = 1'b0;
        meta_waddr = walk_x[AW-1:0];
        meta_wdata = meta_new;
        meta_raddr = at_x[AW-1:0];
        link_we    = 1'b0;
        link_wdata = head_cur;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    cls_next   = size_class;
                    at_next    = address;
                    cnt_next   = word_count;
                    addr_next  = '0;
                    err_next   = E_OK;
                    own_next   = 1'b0;
                    seal_next  = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                idx_next = '0;
                if (op_reg == OP_ALLOC)
                begin
                    ffree_next = 1'b0;
                    if (!cls_ok)
                    begin
                        err_next   = E_CLASS;
                        state_next = S_DONE;
                    end
                    else if (head_cur != '0)
                    begin
                        meta_raddr = head_cur;
                        base_next  = head_cur;
                        if (head_x >= bump_x)
                        begin
                            err_next   = E_LIST;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_LIST;
                        end
                    end
                    else if (size_c > cap_x || bump_x > cap_x - size_c)
                    begin
                        err_next   = E_BUDGET;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        base_next  = bump_reg[AW-1:0];
                        bump_next  = PW'(bump_x + size_c);
                        state_next = S_FILL;
                    end
                end
                else if (op_reg <= OP_QUERY)
                begin
                    if (at_x < HS_X || at_x >= bump_x)
                    begin
                        err_next   = E_SPAN;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SPAN;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LIST:
            begin
                if (meta_rdata != (meta_new | {3'b010, {(MW-3){1'b0}}}))
                begin
                    err_next   = E_LIST;
                    state_next = S_DONE;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = link_rdata;
                    state_next = S_FILL;
                end
            end
            S_SPAN:
            begin
                m_next     = meta_rdata;
                meta_raddr = meta_rdata[AW-1:0];
                state_next = S_DONE;
                if (!span_ok)
                begin
                    err_next = E_SPAN;
                end
                else
                begin
                    priority case (op_reg)
                        OP_FREE:
                        begin
                            if (!match_ok)
                            begin
                                err_next = E_MISMATCH;
                            end
                            else
                            begin
                                base_next  = at_x[AW-1:0];
                                ffree_next = 1'b1;
                                state_next = S_FILL;
                            end
                        end
                        OP_ACHECK:
                        begin
                            if (!match_ok)
                            begin
                                err_next = E_MISMATCH;
                            end
                        end
                        OP_SEAL, OP_UNSEAL:
                        begin
                            if (own_x != at_x)
                            begin
                                err_next = E_HEAD;
                            end
                            else
                            begin
                                meta_we    = 1'b1;
                                meta_waddr = at_x[AW-1:0];
                                meta_wdata = meta_rdata;
                                meta_wdata[B_SEALED] = (op_reg == OP_SEAL);
                            end
                        end
                        OP_MARK_RAW, OP_MARK_OWN, OP_QUERY:
                        begin
                            state_next = S_OWNER;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_OWNER:
            begin
                base_next  = at_x[AW-1:0];
                state_next = S_DONE;
                if (op_reg == OP_QUERY)
                begin
                    own_next  = m_reg[B_OWNED];
                    seal_next = meta_rdata[B_SEALED];
                end
                else if (meta_rdata[B_SEALED])
                begin
                    err_next = E_SEALED;
                end
                else if (cnt_reg != '0)
                begin
                    state_next = S_MRD;
                end
            end
            S_FILL:
            begin
                meta_we = 1'b1;
                if (ffree_reg)
                begin
                    meta_wdata = (idx_reg == '0)
                                 ? (meta_new | {3'b010, {(MW-3){1'b0}}}) : '0;
                end
                else
                begin
                    meta_wdata = meta_new | {3'b100, {(MW-3){1'b0}}};
                end
                idx_next = idx_reg + XW'(1);
                if (idx_next == size_c)
                begin
                    state_next = S_DONE;
                    if (ffree_reg)
                    begin
                        link_we    = 1'b1;
                        head_we    = 1'b1;
                        head_wdata = base_reg;
                        lw_next    = lw_reg - size_c[16:0];
                        lb_next    = lb_reg - 17'd1;
                    end
                    else
                    begin
                        addr_next = 16'(XW'(base_reg));
                        lw_next   = lw_reg + size_c[16:0];
                        lb_next   = lb_reg + 17'd1;
                    end
                end
            end
            S_MRD:
            begin
                meta_raddr = walk_x[AW-1:0];
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                // hold the read address so the write cycle sees this word
                meta_raddr = walk_x[AW-1:0];
                state_next = S_MWR;
            end
            S_MWR:
            begin
                meta_raddr = walk_x[AW-1:0];
                meta_we    = 1'b1;
                meta_wdata = meta_rdata;
                meta_wdata[B_OWNED] = (op_reg == OP_MARK_OWN);
                idx_next   = idx_reg + XW'(1);
                state_next = (idx_next == XW'(cnt_reg)) ? S_DONE : S_MRD;
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg   <= 17'h10000;
            bump_reg  <= PW'(HEAP_START);
            lw_reg    <= '0;
            lb_reg    <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            bump_reg  <= bump_next;
            lw_reg    <= lw_next;
            lb_reg    <= lb_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (head_we)
            begin
                heads_reg[cls_ix] <= head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        cls_reg   <= cls_next;
        at_reg    <= at_next;
        cnt_reg   <= cnt_next;
        m_reg     <= m_next;
        base_reg  <= base_next;
        idx_reg   <= idx_next;
        ffree_reg <= ffree_next;
        addr_reg  <= addr_next;
        err_reg   <= err_next;
        own_reg   <= own_next;
        seal_reg  <= seal_next;
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = (state_reg == S_DONE);
    assign block_address    = addr_reg;
    assign error_code       = err_reg;
    assign owned_flag       = own_reg;
    assign sealed_flag      = seal_reg;
    assign live_word_total  = lw_reg;
    assign live_block_total = lb_reg;

    // a result beat never overlaps an accepted request
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("result shown while input open");
    // bump pointer never passes the heap end
    assert property (@(posedge clk) disable iff (!rst_n) XW'(bump_reg) <= HW_X)
        else $error("bump pointer beyond heap");
    // only a successful alloc reports a block address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && block_address != '0) |-> (error_code == E_OK && op_reg == OP_ALLOC))
        else $error("block address on failed request");
    // block count moves only when a fill walk finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        (lb_reg != $past(lb_reg)) |-> ($past(state_reg) == S_FILL))
        else $error("live block count changed outside fill");
endmodule
`default_nettype wire
